/* rtl/core/tscf_pkg.sv */
package tscf_pkg;

    // Configuration register indexes
    localparam int CFG_INDEX_W = 3;
    localparam logic [CFG_INDEX_W-1:0] CFG_NUMBER_ALL       = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_NUMBER_NONBLANK  = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_SQUEEZE_BLANK    = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_SHOW_ENDS        = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_SHOW_TABS        = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] CFG_SHOW_NONPRINTING = 3'd5;

    // Character codes
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_DASH   = 8'h2D;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_QMARK  = 8'h3F;
    localparam logic [7:0] CH_I      = 8'h49;
    localparam logic [7:0] CH_M      = 8'h4D;
    localparam logic [7:0] CH_CARET  = 8'h5E;
    localparam logic [7:0] CH_DEL    = 8'h7F;
    localparam logic [7:0] CH_ALL    = 8'hFF;
    localparam logic [7:0] CH_HIGH_CTRL_END = 8'hA0;
    localparam logic [7:0] CH_CTRL_END      = 8'h20;
    localparam logic [7:0] CARET_OFFSET     = 8'h40;

    typedef struct packed {
        logic number_all;
        logic number_nonblank;
        logic squeeze_blank;
        logic show_ends;
        logic show_tabs;
        logic show_nonprinting;
    } cfg_t;

    // Output sequence of one byte: number prefix, '$', rendered body
    typedef enum logic [2:0] {
        PH_PAD,
        PH_DIGIT,
        PH_TAB,
        PH_END,
        PH_BODY
    } phase_t;

    typedef struct packed {
        logic [3:0][7:0] bytes;
        logic [1:0]      last_idx;
    } body_t;

endpackage

/* rtl/core/tscf_front.sv */
module tscf_front #(
    parameter int COUNT_DIGITS = 10,
    parameter int PAD_WIDTH    = 6,
    parameter int CNT_W        = 4
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  tscf_pkg::cfg_t                cfg,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [7:0]                    in_byte,
    output logic                          push,
    input  logic                          push_ready,
    output logic [COUNT_DIGITS-1:0][3:0]  e_bcd,
    output tscf_pkg::body_t               e_body,
    output logic                          e_show_end,
    output tscf_pkg::phase_t              e_phase,
    output logic [CNT_W-1:0]              e_cnt,
    output logic [CNT_W-1:0]              e_top
);

    localparam int SIG_W = $clog2(COUNT_DIGITS + 1);

    logic                         at_line_start_reg, at_line_start_next;
    logic [1:0]                   blank_run_reg, blank_run_next;
    logic [COUNT_DIGITS-1:0][3:0] count_reg, count_next, count_inc;
    logic                         accept, nl, drop, do_number, carry, full;
    logic [SIG_W-1:0]             sig;
    logic [CNT_W-1:0]             sig_ext;

    assign in_ready = push_ready;
    assign accept   = in_valid && push_ready;
    assign nl       = (in_byte == tscf_pkg::CH_NL);
    assign push     = accept && !drop;

    // line-start bookkeeping
    always_comb
    begin
        blank_run_next = blank_run_reg;
        if (at_line_start_reg && cfg.squeeze_blank)
        begin
            if (nl)
                blank_run_next = (blank_run_reg == 2'd3) ? 2'd3 : blank_run_reg + 2'd1;
            else
                blank_run_next = 2'd0;
        end
        drop = at_line_start_reg && cfg.squeeze_blank && (blank_run_next > 2'd1);
        do_number = at_line_start_reg && !drop &&
                    (cfg.number_nonblank ? !nl : cfg.number_all);
        at_line_start_next = drop ? 1'b1 : nl;
    end

    // saturating BCD increment
    always_comb
    begin
        carry = 1'b1;
        full  = 1'b1;
        for (int i = 0; i < COUNT_DIGITS; i++)
        begin
            if (carry)
                count_inc[i] = (count_reg[i] >= 4'd9) ? 4'd0 : count_reg[i] + 4'd1;
            else
                count_inc[i] = count_reg[i];
            carry = carry && (count_reg[i] >= 4'd9);
            full  = full && (count_reg[i] == 4'd9);
        end
        count_next = full ? count_reg : count_inc;
    end

    // significant digit count
    always_comb
    begin
        sig = SIG_W'(1);
        for (int i = 1; i < COUNT_DIGITS; i++)
            if (count_reg[i] != 4'd0)
                sig = SIG_W'(i + 1);
        sig_ext = CNT_W'(sig);
    end

    always_comb
    begin
        e_bcd      = count_reg;
        e_show_end = cfg.show_ends && nl;
        e_top      = sig_ext - CNT_W'(1);
        if (do_number)
        begin
            if (sig_ext < CNT_W'(PAD_WIDTH))
            begin
                e_phase = tscf_pkg::PH_PAD;
                e_cnt   = CNT_W'(PAD_WIDTH) - sig_ext;
            end
            else
            begin
                e_phase = tscf_pkg::PH_DIGIT;
                e_cnt   = sig_ext - CNT_W'(1);
            end
        end
        else if (e_show_end)
        begin
            e_phase = tscf_pkg::PH_END;
            e_cnt   = '0;
        end
        else
        begin
            e_phase = tscf_pkg::PH_BODY;
            e_cnt   = '0;
        end
    end

    // render the byte itself
    always_comb
    begin
        e_body          = '0;
        e_body.bytes[0] = in_byte;
        if (cfg.show_tabs && in_byte == tscf_pkg::CH_TAB)
        begin
            e_body.bytes[0] = tscf_pkg::CH_CARET;
            e_body.bytes[1] = tscf_pkg::CH_I;
            e_body.last_idx = 2'd1;
        end
        else if (cfg.show_nonprinting)
        begin
            if (in_byte[7])
            begin
                e_body.bytes[0] = tscf_pkg::CH_M;
                e_body.bytes[1] = tscf_pkg::CH_DASH;
                if (in_byte == tscf_pkg::CH_ALL)
                begin
                    e_body.bytes[2] = tscf_pkg::CH_CARET;
                    e_body.bytes[3] = tscf_pkg::CH_QMARK;
                    e_body.last_idx = 2'd3;
                end
                else if (in_byte < tscf_pkg::CH_HIGH_CTRL_END)
                begin
                    e_body.bytes[2] = tscf_pkg::CH_CARET;
                    e_body.bytes[3] = in_byte - tscf_pkg::CARET_OFFSET;
                    e_body.last_idx = 2'd3;
                end
                else
                begin
                    e_body.bytes[2] = {1'b0, in_byte[6:0]};
                    e_body.last_idx = 2'd2;
                end
            end
            else if (in_byte < tscf_pkg::CH_CTRL_END && in_byte != tscf_pkg::CH_TAB &&
                     in_byte != tscf_pkg::CH_NL)
            begin
                e_body.bytes[0] = tscf_pkg::CH_CARET;
                e_body.bytes[1] = in_byte + tscf_pkg::CARET_OFFSET;
                e_body.last_idx = 2'd1;
            end
            else if (in_byte == tscf_pkg::CH_DEL)
            begin
                e_body.bytes[0] = tscf_pkg::CH_CARET;
                e_body.bytes[1] = tscf_pkg::CH_QMARK;
                e_body.last_idx = 2'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            at_line_start_reg <= 1'b1;
            blank_run_reg     <= 2'd0;
            count_reg         <= (4 * COUNT_DIGITS)'(1);
        end
        else if (accept)
        begin
            at_line_start_reg <= at_line_start_next;
            blank_run_reg     <= blank_run_next;
            if (do_number)
                count_reg <= count_next;
        end
    end

endmodule

/* rtl/core/tscf_queue.sv */
module tscf_queue #(
    parameter int WIDTH = 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    output logic             push_ready,
    input  logic [WIDTH-1:0] push_data,
    output logic             pop_valid,
    input  logic             pop,
    output logic [WIDTH-1:0] pop_data
);

    localparam int DEPTH = 2;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] fill_reg;
    logic             do_push, do_pop;

    assign push_ready = (fill_reg != CNT_W'(DEPTH));
    assign pop_valid  = (fill_reg != '0);
    assign pop_data   = mem_reg[rd_ptr_reg];
    assign do_push    = push && push_ready;
    assign do_pop     = pop && pop_valid;

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= wr_ptr_reg + PTR_W'(1);
            if (do_pop)
                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            if (do_push && !do_pop)
                fill_reg <= fill_reg + CNT_W'(1);
            else if (do_pop && !do_push)
                fill_reg <= fill_reg - CNT_W'(1);
        end
    end

endmodule

/* rtl/core/tscf_back.sv */
module tscf_back #(
    parameter int COUNT_DIGITS = 10,
    parameter int CNT_W        = 4
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          q_valid,
    output logic                          q_pop,
    input  logic [COUNT_DIGITS-1:0][3:0]  q_bcd,
    input  tscf_pkg::body_t               q_body,
    input  logic                          q_show_end,
    input  tscf_pkg::phase_t              q_phase,
    input  logic [CNT_W-1:0]              q_cnt,
    input  logic [CNT_W-1:0]              q_top,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [7:0]                    out_byte,
    output logic                          last_of_run
);

    localparam int DIG_W = (COUNT_DIGITS > 1) ? $clog2(COUNT_DIGITS) : 1;

    logic                         busy_reg, out_valid_reg, last_reg;
    logic [7:0]                   out_byte_reg;
    tscf_pkg::phase_t             phase_reg, src_phase, phase_next;
    logic [CNT_W-1:0]             cnt_reg, src_cnt, cnt_next;
    logic [COUNT_DIGITS-1:0][3:0] cur_bcd, src_bcd;
    tscf_pkg::body_t              cur_body, src_body;
    logic                         cur_show_end, src_show_end;
    logic [CNT_W-1:0]             cur_top, src_top;
    logic                         have, adv, gen_last;
    logic [7:0]                   gen_byte;
    logic [3:0]                   digit, digit_clamp;

    assign have = busy_reg || q_valid;
    assign adv  = !out_valid_reg || out_ready;
    assign q_pop = adv && !busy_reg && q_valid;

    assign out_valid   = out_valid_reg;
    assign out_byte    = out_byte_reg;
    assign last_of_run = last_reg;

    // work on the held item, else start on the queue head this cycle
    always_comb
    begin
        src_phase    = busy_reg ? phase_reg    : q_phase;
        src_cnt      = busy_reg ? cnt_reg      : q_cnt;
        src_bcd      = busy_reg ? cur_bcd      : q_bcd;
        src_body     = busy_reg ? cur_body     : q_body;
        src_show_end = busy_reg ? cur_show_end : q_show_end;
        src_top      = busy_reg ? cur_top      : q_top;
    end

    assign digit       = src_bcd[src_cnt[DIG_W-1:0]];
    assign digit_clamp = (digit > 4'd9) ? 4'd9 : digit;

    always_comb
    begin
        gen_byte   = tscf_pkg::CH_SPACE;
        gen_last   = 1'b0;
        phase_next = src_phase;
        cnt_next   = src_cnt;
        unique case (src_phase)
            tscf_pkg::PH_PAD:
            begin
                gen_byte = tscf_pkg::CH_SPACE;
                if (src_cnt == CNT_W'(1))
                begin
                    phase_next = tscf_pkg::PH_DIGIT;
                    cnt_next   = src_top;
                end
                else
                    cnt_next = src_cnt - CNT_W'(1);
            end
            tscf_pkg::PH_DIGIT:
            begin
                gen_byte = tscf_pkg::CH_ZERO + {4'h0, digit_clamp};
                if (src_cnt == '0)
                    phase_next = tscf_pkg::PH_TAB;
                else
                    cnt_next = src_cnt - CNT_W'(1);
            end
            tscf_pkg::PH_TAB:
            begin
                gen_byte   = tscf_pkg::CH_TAB;
                phase_next = src_show_end ? tscf_pkg::PH_END : tscf_pkg::PH_BODY;
                cnt_next   = '0;
            end
            tscf_pkg::PH_END:
            begin
                gen_byte   = tscf_pkg::CH_DOLLAR;
                phase_next = tscf_pkg::PH_BODY;
                cnt_next   = '0;
            end
            tscf_pkg::PH_BODY:
            begin
                gen_byte = src_body.bytes[src_cnt[1:0]];
                if (src_cnt[1:0] == src_body.last_idx)
                    gen_last = 1'b1;
                else
                    cnt_next = src_cnt + CNT_W'(1);
            end
            default:
            begin
                gen_last = 1'b1;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            cur_bcd      <= q_bcd;
            cur_body     <= q_body;
            cur_show_end <= q_show_end;
            cur_top      <= q_top;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            out_byte_reg  <= '0;
            last_reg      <= 1'b0;
            phase_reg     <= tscf_pkg::PH_BODY;
            cnt_reg       <= '0;
        end
        else if (adv)
        begin
            out_valid_reg <= have;
            if (have)
            begin
                out_byte_reg <= gen_byte;
                last_reg     <= gen_last;
                busy_reg     <= !gen_last;
                phase_reg    <= phase_next;
                cnt_reg      <= cnt_next;
            end
        end
    end

endmodule

/* rtl/core/text_stream_cat_formatter.sv */
// Byte stream formatter with cat-style line numbering, blank-line squeezing,
// '$' line ends, ^I tabs and ^ / M- notation for nonprinting bytes. Each
// accepted input byte yields one or more output beats on out_byte, the last
// of them flagged by last_of_run; a squeezed blank line yields none. The
// back end sends one beat per cycle while out_ready is high; a numbered line
// start adds up to COUNT_DIGITS digits or PAD_WIDTH padded places plus a
// tab. Input accepts one byte per cycle while the two-entry queue between
// classifier and emitter has room, so plain text streams at one byte per
// cycle when out_ready stays high. Line numbers are BCD with COUNT_DIGITS
// digits and stick at all nines. Configuration is register index plus
// data bit 0, taken every cycle; write it only while idle.
module text_stream_cat_formatter #(
    parameter int COUNT_DIGITS = 10,
    parameter int PAD_WIDTH    = 6
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic [7:0]                       in_byte,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [7:0]                       out_byte,
    output logic                             last_of_run,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [tscf_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic                             cfg_data
);

    localparam int CNT_MAX = (PAD_WIDTH > COUNT_DIGITS) ? PAD_WIDTH : COUNT_DIGITS;
    localparam int CNT_W   = $clog2(CNT_MAX + 1);
    localparam int BCD_W   = 4 * COUNT_DIGITS;
    localparam int BODY_W  = $bits(tscf_pkg::body_t);
    localparam int PH_W    = $bits(tscf_pkg::phase_t);
    localparam int ENTRY_W = BCD_W + BODY_W + 1 + PH_W + 2 * CNT_W;

    tscf_pkg::cfg_t               cfg_reg;
    logic                         push, push_ready, q_valid, q_pop;
    logic [ENTRY_W-1:0]           push_data, pop_data;
    logic [COUNT_DIGITS-1:0][3:0] e_bcd, q_bcd;
    tscf_pkg::body_t              e_body, q_body;
    logic                         e_show_end, q_show_end;
    tscf_pkg::phase_t             e_phase, q_phase;
    logic [PH_W-1:0]              q_phase_bits;
    logic [CNT_W-1:0]             e_cnt, q_cnt, e_top, q_top;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cfg_reg <= '0;
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                tscf_pkg::CFG_NUMBER_ALL:       cfg_reg.number_all       <= cfg_data;
                tscf_pkg::CFG_NUMBER_NONBLANK:  cfg_reg.number_nonblank  <= cfg_data;
                tscf_pkg::CFG_SQUEEZE_BLANK:    cfg_reg.squeeze_blank    <= cfg_data;
                tscf_pkg::CFG_SHOW_ENDS:        cfg_reg.show_ends        <= cfg_data;
                tscf_pkg::CFG_SHOW_TABS:        cfg_reg.show_tabs        <= cfg_data;
                tscf_pkg::CFG_SHOW_NONPRINTING: cfg_reg.show_nonprinting <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    tscf_front #(
        .COUNT_DIGITS (COUNT_DIGITS),
        .PAD_WIDTH    (PAD_WIDTH),
        .CNT_W        (CNT_W)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_byte    (in_byte),
        .push       (push),
        .push_ready (push_ready),
        .e_bcd      (e_bcd),
        .e_body     (e_body),
        .e_show_end (e_show_end),
        .e_phase    (e_phase),
        .e_cnt      (e_cnt),
        .e_top      (e_top)
    );

    assign push_data = {e_bcd, e_body, e_show_end, e_phase, e_cnt, e_top};
    assign {q_bcd, q_body, q_show_end, q_phase_bits, q_cnt, q_top} = pop_data;
    assign q_phase = tscf_pkg::phase_t'(q_phase_bits);

    tscf_queue #(
        .WIDTH (ENTRY_W)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (q_valid),
        .pop        (q_pop),
        .pop_data   (pop_data)
    );

    tscf_back #(
        .COUNT_DIGITS (COUNT_DIGITS),
        .CNT_W        (CNT_W)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_valid     (q_valid),
        .q_pop       (q_pop),
        .q_bcd       (q_bcd),
        .q_body      (q_body),
        .q_show_end  (q_show_end),
        .q_phase     (q_phase),
        .q_cnt       (q_cnt),
        .q_top       (q_top),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_byte    (out_byte),
        .last_of_run (last_of_run)
    );

endmodule

/* sim/text_stream_cat_formatter_tb.sv */
module text_stream_cat_formatter_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int COUNT_DIGITS   = 10;
    localparam int PAD_WIDTH      = 6;
    localparam int DRAIN_CYCLES   = 16;
    localparam int LONG_HOLD      = 400;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int RANDOM_PHASES  = 10;
    localparam int PHASE_ITEMS    = 33;

    localparam logic [7:0] HIGH_BIT = 8'h80;
    localparam logic [7:0] CH_LOW_X = 8'h78;
    localparam logic [7:0] CH_TILDE = 8'h7E;
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_US    = 8'h1F;
    localparam logic [7:0] CH_M_US  = 8'h9F;
    localparam logic [7:0] CH_M_FE  = 8'hFE;

    // Indexes past the last register; writes there must change nothing
    localparam logic [tscf_pkg::CFG_INDEX_W-1:0] CFG_SPARE_LO = 3'd6;
    localparam logic [tscf_pkg::CFG_INDEX_W-1:0] CFG_SPARE_HI = 3'd7;

    class cat_scoreboard;
        typedef struct {
            logic [7:0] data;
            logic       last;
        } beat_t;

        tscf_pkg::cfg_t             cfg;
        logic                       at_line_start;
        logic [1:0]                 blank_run;
        logic [4*COUNT_DIGITS-1:0]  line_bcd;
        beat_t                      expected_beats[$];
        int                         errors;

        function new();
            cfg           = '0;
            at_line_start = 1'b1;
            blank_run     = '0;
            line_bcd      = 1;
            errors        = 0;
        endfunction

        function void write_reg(logic [tscf_pkg::CFG_INDEX_W-1:0] index, logic data);
            case (index)
                tscf_pkg::CFG_NUMBER_ALL:       cfg.number_all       = data;
                tscf_pkg::CFG_NUMBER_NONBLANK:  cfg.number_nonblank  = data;
                tscf_pkg::CFG_SQUEEZE_BLANK:    cfg.squeeze_blank    = data;
                tscf_pkg::CFG_SHOW_ENDS:        cfg.show_ends        = data;
                tscf_pkg::CFG_SHOW_TABS:        cfg.show_tabs        = data;
                tscf_pkg::CFG_SHOW_NONPRINTING: cfg.show_nonprinting = data;
                default: ;
            endcase
        endfunction

        function void put(logic [7:0] b);
            beat_t bt;
            bt.data = b;
            bt.last = 1'b0;
            expected_beats.push_back(bt);
        endfunction

        function logic [3:0] digit_at(int i);
            return line_bcd[4*i +: 4];
        endfunction

        function void put_line_number();
            int sig;
            logic [3:0] d;
            logic full;
            sig = 1;
            for (int i = COUNT_DIGITS - 1; i > 0; i--)
            begin
                if (digit_at(i) != 4'd0)
                begin
                    sig = i + 1;
                    break;
                end
            end
            for (int i = sig; i < PAD_WIDTH; i++)
                put(tscf_pkg::CH_SPACE);
            for (int i = sig - 1; i >= 0; i--)
            begin
                d = digit_at(i);
                put(tscf_pkg::CH_ZERO + ((d > 4'd9) ? 8'd9 : {4'd0, d}));
            end
            put(tscf_pkg::CH_TAB);

            // advance the BCD counter, stick at all nines
            full = 1'b1;
            for (int i = 0; i < COUNT_DIGITS; i++)
                if (digit_at(i) != 4'd9)
                    full = 1'b0;
            if (!full)
            begin
                for (int i = 0; i < COUNT_DIGITS; i++)
                begin
                    d = digit_at(i);
                    if (d >= 4'd9)
                    begin
                        line_bcd[4*i +: 4] = 4'd0;
                    end
                    else
                    begin
                        line_bcd[4*i +: 4] = d + 4'd1;
                        break;
                    end
                end
            end
        endfunction

        function void put_visible(logic [7:0] c);
            if (c >= HIGH_BIT && c < tscf_pkg::CH_HIGH_CTRL_END)
            begin
                put(tscf_pkg::CH_M);
                put(tscf_pkg::CH_DASH);
                put(tscf_pkg::CH_CARET);
                put(c - tscf_pkg::CARET_OFFSET);
            end
            else if (c >= tscf_pkg::CH_HIGH_CTRL_END && c < tscf_pkg::CH_ALL)
            begin
                put(tscf_pkg::CH_M);
                put(tscf_pkg::CH_DASH);
                put(c - HIGH_BIT);
            end
            else if (c == tscf_pkg::CH_ALL)
            begin
                put(tscf_pkg::CH_M);
                put(tscf_pkg::CH_DASH);
                put(tscf_pkg::CH_CARET);
                put(tscf_pkg::CH_QMARK);
            end
            else if (c < tscf_pkg::CH_CTRL_END && c != tscf_pkg::CH_TAB &&
                     c != tscf_pkg::CH_NL)
            begin
                put(tscf_pkg::CH_CARET);
                put(c + tscf_pkg::CARET_OFFSET);
            end
            else if (c == tscf_pkg::CH_DEL)
            begin
                put(tscf_pkg::CH_CARET);
                put(tscf_pkg::CH_QMARK);
            end
            else
            begin
                put(c);
            end
        endfunction

        function void note_input(logic [7:0] c);
            logic nl;
            nl = (c == tscf_pkg::CH_NL);
            if (at_line_start)
            begin
                if (cfg.squeeze_blank)
                begin
                    if (nl)
                        blank_run = (blank_run < 2'd3) ? blank_run + 2'd1 : 2'd3;
                    else
                        blank_run = 2'd0;
                    // drop a repeated blank line, stay at line start
                    if (blank_run > 2'd1)
                        return;
                end
                if (cfg.number_nonblank)
                begin
                    if (!nl)
                        put_line_number();
                end
                else if (cfg.number_all)
                begin
                    put_line_number();
                end
            end
            if (cfg.show_ends && nl)
                put(tscf_pkg::CH_DOLLAR);
            if (cfg.show_tabs && c == tscf_pkg::CH_TAB)
            begin
                put(tscf_pkg::CH_CARET);
                put(tscf_pkg::CH_I);
            end
            else if (cfg.show_nonprinting)
            begin
                put_visible(c);
            end
            else
            begin
                put(c);
            end
            at_line_start = nl;
            expected_beats[expected_beats.size() - 1].last = 1'b1;
        endfunction

        function void check_beat(logic [7:0] data, logic last);
            beat_t exp_beat;
            if (expected_beats.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected beat out_byte=%h last_of_run=%b",
                         $time, data, last);
                return;
            end
            exp_beat = expected_beats.pop_front();
            if (data !== exp_beat.data)
            begin
                errors++;
                $display("%0t: out_byte expected %h actual %h",
                         $time, exp_beat.data, data);
            end
            if (last !== exp_beat.last)
            begin
                errors++;
                $display("%0t: last_of_run expected %b actual %b",
                         $time, exp_beat.last, last);
            end
        endfunction

        function int pending();
            return expected_beats.size();
        endfunction
    endclass

    logic                             clk;
    logic                             rst_n;
    logic                             in_valid;
    logic                             in_ready;
    logic [7:0]                       in_byte;
    logic                             out_valid;
    logic                             out_ready;
    logic [7:0]                       out_byte;
    logic                             last_of_run;
    logic                             cfg_valid;
    logic                             cfg_ready;
    logic [tscf_pkg::CFG_INDEX_W-1:0] cfg_index;
    logic                             cfg_data;

    cat_scoreboard sb = new();
    logic hold_request = 1'b0;
    int   burst_left   = 0;
    int   idle_cycles  = 0;

    text_stream_cat_formatter #(
        .COUNT_DIGITS(COUNT_DIGITS),
        .PAD_WIDTH   (PAD_WIDTH)
    ) DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_byte    (in_byte),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_byte   (out_byte),
        .last_of_run(last_of_run),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Monitor: sample handshakes at the edge, note inputs before checking outputs
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
                sb.write_reg(cfg_index, cfg_data);
            if (in_valid && in_ready)
                sb.note_input(in_byte);
            if (out_valid && out_ready)
                sb.check_beat(out_byte, last_of_run);
        end
    end

    initial
    begin
        forever
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready) ||
                (cfg_valid && cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("tb: failure");
                $finish;
            end
        end
    end

    // Receiver: random stall pattern among four modes; long hold on request
    initial
    begin
        int ready_cycle;
        int ready_mode;
        ready_cycle = 0;
        ready_mode  = 0;
        out_ready   = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                out_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
                hold_request = 1'b0;
            end
            ready_cycle++;
            if (ready_cycle % 96 == 0)
                ready_mode = $urandom_range(0, 3);
            case (ready_mode)
                0: out_ready <= 1'b1;
                1: out_ready <= 1'($urandom_range(0, 1));
                2: out_ready <= ($urandom_range(0, 4) == 0);
                default: out_ready <= ((ready_cycle % 7) >= 3);
            endcase
        end
    end

    task automatic send_byte(input logic [7:0] b);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        in_valid <= 1'b1;
        in_byte  <= b;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        burst_left--;
    endtask

    task automatic write_reg(input logic [tscf_pkg::CFG_INDEX_W-1:0] index,
                             input logic data);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
    endtask

    // Drop valid and wait until every expected beat has come out
    task automatic drain();
        in_valid   <= 1'b0;
        burst_left = 0;
        // let the monitor note the last accepted beat before counting
        @(posedge clk);
        while (sb.pending() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic program_config(input tscf_pkg::cfg_t c);
        drain();
        write_reg(tscf_pkg::CFG_NUMBER_ALL,       c.number_all);
        write_reg(tscf_pkg::CFG_NUMBER_NONBLANK,  c.number_nonblank);
        write_reg(tscf_pkg::CFG_SQUEEZE_BLANK,    c.squeeze_blank);
        write_reg(tscf_pkg::CFG_SHOW_ENDS,        c.show_ends);
        write_reg(tscf_pkg::CFG_SHOW_TABS,        c.show_tabs);
        write_reg(tscf_pkg::CFG_SHOW_NONPRINTING, c.show_nonprinting);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [7:0] pick_text_byte();
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: return 8'($urandom_range(32, 126));
            6:                return tscf_pkg::CH_TAB;
            7:                return 8'($urandom_range(0, 255));
            8:                return 8'($urandom_range(128, 255));
            default:          return 8'($urandom_range(0, 31));
        endcase
    endfunction

    // Mostly whole lines and blank-line runs, some loose noise
    task automatic send_line_traffic(input int n_items);
        int count;
        int pick;
        int len;
        count = 0;
        while (count < n_items)
        begin
            pick = $urandom_range(0, 9);
            if (pick < 2)
            begin
                len = $urandom_range(1, 4);
                repeat (len) send_byte(tscf_pkg::CH_NL);
                count += len;
            end
            else if (pick < 9)
            begin
                len = $urandom_range(0, 12);
                repeat (len) send_byte(pick_text_byte());
                send_byte(tscf_pkg::CH_NL);
                count += len + 1;
            end
            else
            begin
                len = $urandom_range(1, 6);
                repeat (len) send_byte(8'($urandom_range(0, 255)));
                count += len;
            end
        end
    endtask

    initial
    begin
        tscf_pkg::cfg_t c;
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        in_byte   = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset defaults, plus writes to the spare indexes
        write_reg(CFG_SPARE_LO, 1'b1);
        write_reg(CFG_SPARE_HI, 1'b1);
        cfg_valid <= 1'b0;
        send_byte(CH_NUL);
        send_byte(tscf_pkg::CH_ALL);
        send_byte(tscf_pkg::CH_TAB);
        send_byte(CH_LOW_X);
        send_byte(tscf_pkg::CH_NL);

        // Every mode but nonblank numbering on: squeezed blank runs, all caret and M- classes
        program_config(tscf_pkg::cfg_t'('1));
        c = '1;
        c.number_nonblank = 1'b0;
        program_config(c);
        repeat (4) send_byte(tscf_pkg::CH_NL);
        send_byte(CH_NUL);
        send_byte(CH_US);
        send_byte(tscf_pkg::CH_DEL);
        send_byte(HIGH_BIT);
        send_byte(CH_M_US);
        send_byte(tscf_pkg::CH_HIGH_CTRL_END);
        send_byte(CH_M_FE);
        send_byte(tscf_pkg::CH_ALL);
        send_byte(tscf_pkg::CH_TAB);
        send_byte(tscf_pkg::CH_SPACE);
        send_byte(CH_TILDE);
        send_byte(tscf_pkg::CH_NL);

        // Nonblank numbering over number_all; tab and newline pass through
        c = '0;
        c.number_all       = 1'b1;
        c.number_nonblank  = 1'b1;
        c.show_nonprinting = 1'b1;
        program_config(c);
        send_byte(tscf_pkg::CH_TAB);
        send_byte(tscf_pkg::CH_NL);
        send_byte(tscf_pkg::CH_NL);
        send_byte(CH_LOW_X);
        send_byte(tscf_pkg::CH_NL);

        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            if (phase == 0)
                c = '1;
            else if (phase == 1)
                c = '0;
            else
                c = tscf_pkg::cfg_t'(6'($urandom_range(0, 63)));
            program_config(c);
            if (phase == 3)
                hold_request = 1'b1;
            send_line_traffic(PHASE_ITEMS);
        end

        drain();
        if (sb.errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

/* files.f */
rtl/core/tscf_pkg.sv
rtl/core/tscf_front.sv
rtl/core/tscf_queue.sv
rtl/core/tscf_back.sv
rtl/core/text_stream_cat_formatter.sv
sim/text_stream_cat_formatter_tb.sv
